### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLS;

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // field widths of the channels
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  localparam int TAB_STEP = 8;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } req_t;

  typedef struct packed {
    logic                 valid;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    cell_t                cell_val;
  } res_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

endpackage

### rtl/tcw_ifs.sv
// ----------------------------------------------------------------------------
// tcw_ifs
// Request and result channels of the text console writer.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (output valid, cmd, char_code, read_row, read_col, input ready);
  modport sink   (input valid, cmd, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_col;
  logic [CELL_W-1:0]    cell_value;

  modport source (output valid, cursor_row, cursor_col, cell_value, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_value, output ready);
endinterface

### rtl/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem import tcw_pkg::*; (
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output cell_t   rdata
);

  cell_t cells [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cells[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= cells[rd.addr];
    end
  end

endmodule

### rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor, color registers and command sequencer. Single cell writes go out
// at accept; scroll, clear and the reset clear run as one sweep over the
// store; a moved cell is written in the cycle after its read.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  req_t                  item,
  output logic                  idle,
  output res_t                  res,
  output mem_wr_t               mem_wr,
  output mem_rd_t               mem_rd,
  input  cell_t                 rdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t             state;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  addr_t              cnt;
  logic               move;
  logic               report;
  cell_t              fill;
  logic               pv;
  addr_t              pa;
  logic               pm;

  cell_t              blank;
  addr_t              row_base;
  logic [COL_W:0]     col_x;
  logic [ROW_W:0]     row_x;
  logic               put_we;
  addr_t              put_addr;
  cell_t              put_data;
  logic               scroll;
  logic               rd_ok;
  addr_t              rd_addr;
  logic               move_now;

  assign blank    = {bg, fg, CH_SPACE};
  assign idle     = (state == ST_IDLE);
  assign move_now = move && (cnt < ADDR_W'(CELL_COUNT - COLS));

  // next cursor and cell write of a put
  always_comb begin
    row_base = ADDR_W'(cur_row) * ADDR_W'(COLS);
    col_x    = {1'b0, cur_col};
    row_x    = {1'b0, cur_row};
    put_we   = 1'b0;
    put_addr = row_base + ADDR_W'(cur_col);
    put_data = {bg, fg, item.char_code};
    scroll   = 1'b0;
    case (item.char_code)
      CH_LF: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      CH_CR: begin
        col_x = '0;
      end
      CH_TAB: begin
        col_x = (col_x + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
      end
      CH_BS: begin
        if (cur_col != '0) begin
          col_x    = col_x - 1'b1;
          put_we   = 1'b1;
          put_addr = put_addr - 1'b1;
          put_data = blank;
        end
      end
      default: begin
        put_we = 1'b1;
        col_x  = col_x + 1'b1;
      end
    endcase
    if (col_x >= (COL_W+1)'(COLS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    if (row_x >= (ROW_W+1)'(ROWS)) begin
      scroll = 1'b1;
      row_x  = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_comb begin
    rd_ok   = (int'(item.read_row) < ROWS) && (int'(item.read_col) < COLS);
    rd_addr = ADDR_W'(item.read_row) * ADDR_W'(COLS) + ADDR_W'(item.read_col);
  end

  // memory ports and result
  always_comb begin
    mem_wr    = '0;
    mem_rd    = '0;
    res       = '0;
    res.row   = OUT_ROW_W'(cur_row);
    res.col   = OUT_COL_W'(cur_col);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            CMD_PUT: begin
              mem_wr.en   = put_we;
              mem_wr.addr = put_addr;
              mem_wr.data = put_data;
              res.valid   = !scroll;
              res.row     = OUT_ROW_W'(row_x);
              res.col     = OUT_COL_W'(col_x);
            end
            CMD_READ: begin
              mem_rd.en   = rd_ok;
              mem_rd.addr = rd_addr;
              res.valid   = !rd_ok;
            end
            CMD_CLEAR: begin
              res.valid = 1'b0;
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res.valid    = 1'b1;
        res.cell_val = rdata;
      end
      ST_SWEEP: begin
        mem_rd.en   = move_now;
        mem_rd.addr = cnt + ADDR_W'(COLS);
      end
      ST_DRAIN: begin
        res.valid = report;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
    if (pv) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = pa;
      mem_wr.data = pm ? rdata : fill;
    end
  end

  always_ff @(posedge clk) begin
    pa <= cnt;
    pm <= move_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_SWEEP;
      cnt     <= '0;
      move    <= 1'b0;
      report  <= 1'b0;
      fill    <= '0;
      pv      <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      fg      <= FG_RESET;
      bg      <= BG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FG:  fg <= cfg_data;
          REG_BG:  bg <= cfg_data;
          default: fg <= fg;
        endcase
      end
      pv <= (state == ST_SWEEP);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.cmd)
              CMD_PUT: begin
                cur_row <= ROW_W'(row_x);
                cur_col <= COL_W'(col_x);
                if (scroll) begin
                  state  <= ST_SWEEP;
                  cnt    <= '0;
                  move   <= 1'b1;
                  fill   <= blank;
                  report <= 1'b1;
                end
              end
              CMD_READ: begin
                if (rd_ok) begin
                  state <= ST_READ;
                end
              end
              CMD_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                state   <= ST_SWEEP;
                cnt     <= '0;
                move    <= 1'b0;
                fill    <= blank;
                report  <= 1'b1;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine: screen cell store, cursor, put/read/clear requests.
//
//   channel  dir  payload                                  handshake
//   req      in   cmd, char_code, read_row, read_col       valid/ready
//   rsp      out  cursor_row, cursor_col, cell_value       valid/ready
//   cfg      in   cfg_addr, cfg_data                       cfg_we
//
// Put, unused commands and a read out of range register their result at accept;
// an in-range read passes through the registered store read and ST_READ first.
// Scroll and clear sweep the store one cell per cycle, then report in ST_DRAIN.
// After reset a clearing pass over all CELL_COUNT cells zeroes the store;
// req.ready stays low until it ends.
// A stalled result is held in the output register; the next request is taken
// when that register is empty or being drained.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tcw_req_if.sink               req,
  tcw_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  req_t    item;
  res_t    res;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  cell_t   rdata;
  logic    idle;
  logic    accept;

  logic                 out_valid;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  cell_t                out_cell;

  assign item.cmd       = req.cmd;
  assign item.char_code = req.char_code;
  assign item.read_row  = req.read_row;
  assign item.read_col  = req.read_col;

  assign req.ready = idle && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .idle     (idle),
    .res      (res),
    .mem_wr   (mem_wr),
    .mem_rd   (mem_rd),
    .rdata    (rdata)
  );

  tcw_screen_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_row  <= res.row;
      out_col  <= res.col;
      out_cell <= res.cell_val;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cursor_row = out_row;
  assign rsp.cursor_col = out_col;
  assign rsp.cell_value = out_cell;

endmodule
